// ----- rtl/core/tts_pkg.sv -----
`timescale 1ns / 1ps
package tts_pkg;
  localparam int ENTRIES = 16;
  localparam int SLOT_W = $clog2(ENTRIES);
  localparam int TIME_W = 48;
  localparam int ID_W = 32;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [2:0] RES_ADDED = 3'd0;
  localparam logic [2:0] RES_FULL = 3'd1;
  localparam logic [2:0] RES_REMOVED = 3'd2;
  localparam logic [2:0] RES_NOT_FOUND = 3'd3;
  localparam logic [2:0] RES_EXPIRED = 3'd4;

  typedef struct packed {
    logic [1:0] opcode;
    logic [31:0] delay;
    logic repeat_req;
    logic [31:0] target_id;
  } tts_in_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [31:0] entry_id;
    logic last;
  } tts_out_t;
endpackage

// ----- rtl/core/timer_task_scheduler.sv -----
`timescale 1ns / 1ps
// Channel | ports                          | payload
// in      | in_valid / in_ready / in_data  | tts_in_t  (opcode, delay, repeat_req, target_id)
// out     | out_valid / out_ready/ out_data| tts_out_t (event_res, entry_id, last)
//
// Add: the result register is loaded as the executor takes the request.
// Remove: the result follows a linear id match over the slot table.
// Tick: a single scan of the slots when nothing is due. With due entries, each
//   firing is a full scan for the earliest (expiry, id) due entry plus a fire
//   state, and the last result drains before the next request.
// Reset (rst_n low, synchronous) empties the table and zeroes time and id counter.
// A two-request queue fronts the executor, so requests are taken while results
// stall; the result register holds until out_ready.
module timer_task_scheduler (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  tts_pkg::tts_in_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output tts_pkg::tts_out_t out_data
);
  import tts_pkg::*;
  logic q_valid, q_ready;
  tts_in_t q_data;

  tts_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_valid, .q_ready, .q_data
  );

  tts_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .out_data
  );
endmodule

// ----- rtl/core/tts_front.sv -----
`timescale 1ns / 1ps
// Two-entry request queue; drops the unused opcode.
module tts_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  tts_pkg::tts_in_t in_data,
  output logic q_valid,
  input  logic q_ready,
  output tts_pkg::tts_in_t q_data
);
  import tts_pkg::*;
  tts_in_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop, keep;

  assign in_ready = (cnt_r != 2'd2);
  assign keep = (in_data.opcode == OP_ADD) || (in_data.opcode == OP_REMOVE) ||
                (in_data.opcode == OP_TICK);
  assign push = in_valid && in_ready && keep;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = mem_r[rp_r];
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_data;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- rtl/core/tts_back.sv -----
`timescale 1ns / 1ps
// Executes one request at a time. A tick repeatedly scans the slots, one slot a
// cycle, picking the earliest due entry, then fires it.
module tts_back (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_ready,
  input  tts_pkg::tts_in_t q_data,
  output logic out_valid,
  input  logic out_ready,
  output tts_pkg::tts_out_t out_data
);
  import tts_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FIRE, S_REM, S_WAIT} state_t;
  state_t state_r;
  logic [TIME_W-1:0] now_r;
  logic [ID_W-1:0] next_id_r;
  logic [ENTRIES-1:0] valid_r, due_r;
  logic [TIME_W-1:0] exp_r [ENTRIES];
  logic [ID_W-1:0] ival_r [ENTRIES];
  logic [ID_W-1:0] id_r [ENTRIES];
  logic [ENTRIES-1:0] rep_r;
  logic [SLOT_W-1:0] idx_r, best_r;
  logic have_r, more_r;
  logic [ID_W-1:0] tgt_r;
  logic found_r;
  tts_in_t req;
  logic [SLOT_W-1:0] free_slot;
  logic any_free;
  logic [ID_W-1:0] id_nxt;
  logic better;
  logic [ID_W-1:0] iv;
  logic idx_last;

  assign req = q_data;
  assign q_ready = (state_r == S_IDLE);
  assign idx_last = (idx_r == SLOT_W'(ENTRIES - 1));

  always_comb begin
    free_slot = '0;
    any_free = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_slot = SLOT_W'(i);
        any_free = 1'b1;
      end
    end
  end

  assign id_nxt = (next_id_r == '1) ? ID_W'(1) : next_id_r + ID_W'(1);
  assign better = due_r[idx_r] && (!have_r || exp_r[idx_r] < exp_r[best_r] ||
                  (exp_r[idx_r] == exp_r[best_r] && id_r[idx_r] < id_r[best_r]));
  assign iv = (ival_r[best_r] == '0) ? ID_W'(1) : ival_r[best_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      now_r <= '0;
      next_id_r <= '0;
      valid_r <= '0;
      due_r <= '0;
      out_valid <= 1'b0;
      idx_r <= '0;
      best_r <= '0;
      have_r <= 1'b0;
      more_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      // the fire state reloads the result register itself when it drains
      if (out_valid && out_ready && state_r != S_FIRE) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            case (req.opcode)
              OP_ADD: begin
                out_valid <= 1'b1;
                out_data.last <= 1'b1;
                if (any_free) begin
                  next_id_r <= id_nxt;
                  valid_r[free_slot] <= 1'b1;
                  exp_r[free_slot] <= now_r + TIME_W'(req.delay);
                  ival_r[free_slot] <= req.delay;
                  rep_r[free_slot] <= req.repeat_req;
                  id_r[free_slot] <= id_nxt;
                  out_data.event_res <= RES_ADDED;
                  out_data.entry_id <= id_nxt;
                end else begin
                  out_data.event_res <= RES_FULL;
                  out_data.entry_id <= '0;
                end
                state_r <= S_WAIT;
              end
              OP_REMOVE: begin
                tgt_r <= req.target_id;
                found_r <= 1'b0;
                idx_r <= '0;
                state_r <= S_REM;
              end
              default: begin
                now_r <= now_r + TIME_W'(1);
                for (int i = 0; i < ENTRIES; i++)
                  due_r[i] <= valid_r[i] && (exp_r[i] <= now_r + TIME_W'(1));
                idx_r <= '0;
                have_r <= 1'b0;
                more_r <= 1'b0;
                state_r <= S_SCAN;
              end
            endcase
          end
        end
        S_REM: begin
          if (valid_r[idx_r] && id_r[idx_r] == tgt_r) begin
            valid_r[idx_r] <= 1'b0;
            found_r <= 1'b1;
          end
          if (idx_last) begin
            out_valid <= 1'b1;
            out_data.last <= 1'b1;
            if (found_r || (valid_r[idx_r] && id_r[idx_r] == tgt_r)) begin
              out_data.event_res <= RES_REMOVED;
              out_data.entry_id <= tgt_r;
            end else begin
              out_data.event_res <= RES_NOT_FOUND;
              out_data.entry_id <= '0;
            end
            state_r <= S_WAIT;
          end
          idx_r <= idx_r + SLOT_W'(1);
        end
        S_SCAN: begin
          // more_r: a second due entry was seen, so this one is not the last
          if (due_r[idx_r]) begin
            if (have_r) more_r <= 1'b1;
            have_r <= 1'b1;
          end
          if (better) best_r <= idx_r;
          if (idx_last) state_r <= (have_r || due_r[idx_r]) ? S_FIRE : S_IDLE;
          idx_r <= idx_r + SLOT_W'(1);
        end
        S_FIRE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data.event_res <= RES_EXPIRED;
            out_data.entry_id <= id_r[best_r];
            out_data.last <= !more_r;
            due_r[best_r] <= 1'b0;
            if (rep_r[best_r]) exp_r[best_r] <= now_r + TIME_W'(iv);
            else valid_r[best_r] <= 1'b0;
            idx_r <= '0;
            have_r <= 1'b0;
            more_r <= 1'b0;
            state_r <= more_r ? S_SCAN : S_WAIT;
          end
        end
        S_WAIT: begin
          if (!out_valid || out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/core/tts_checker.sv -----
`timescale 1ns / 1ps
module tts_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input tts_pkg::tts_in_t in_data,
  input logic out_valid,
  input logic out_ready,
  input tts_pkg::tts_out_t out_data
);
  import tts_pkg::*;
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request dropped or changed while stalled");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");
  a_res_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.event_res <= RES_EXPIRED)
    else $error("bad result code");
  a_add_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_res != RES_EXPIRED |-> out_data.last)
    else $error("add/remove result without last");
  a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_res == RES_FULL || out_data.event_res == RES_NOT_FOUND)
    |-> out_data.entry_id == '0)
    else $error("failure result with nonzero id");
endmodule

bind timer_task_scheduler tts_checker u_tts_checker (.*);

// ----- tb/timer_task_scheduler_tb.sv -----
`timescale 1ns / 1ps
module timer_task_scheduler_tb;
  import tts_pkg::*;

  // Directed request table. has_exp marks rows whose single result is typed in and
  // checked against the timer-table predictor, which every row goes through.
  typedef struct {
    tts_in_t req;
    bit has_exp;
    tts_out_t exp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  tts_in_t in_data = '0;
  logic in_ready;
  logic out_valid;
  tts_out_t out_data;

  timer_task_scheduler DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #4 clk = ~clk;

  // Predictor state: mirror of the timer table.
  logic [TIME_W-1:0] now_ticks;
  logic [ID_W-1:0] id_ctr;
  bit live[ENTRIES];
  logic [TIME_W-1:0] due_at[ENTRIES];
  logic [ID_W-1:0] period[ENTRIES];
  bit rearm[ENTRIES];
  logic [ID_W-1:0] tid[ENTRIES];

  tts_out_t pending_events[$];
  int fails = 0;
  bit quiet = 1'b0;
  int stall_cnt = 0;
  int n_fired = 0;

  function automatic tts_out_t mk(logic [2:0] r, logic [ID_W-1:0] id, logic l);
    tts_out_t o;
    o.event_res = r;
    o.entry_id = id;
    o.last = l;
    return o;
  endfunction

  function automatic tts_in_t mk_req(logic [1:0] op, logic [31:0] d, logic rp,
                                     logic [31:0] t);
    tts_in_t q;
    q.opcode = op;
    q.delay = d;
    q.repeat_req = rp;
    q.target_id = t;
    return q;
  endfunction

  function automatic void queue_event(tts_out_t e);
    pending_events = {pending_events, e};
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    foreach (live[i]) if (live[i]) n++;
    return n;
  endfunction

  function automatic logic [ID_W-1:0] some_live_id();
    int pick;
    pick = $urandom_range(ENTRIES - 1);
    for (int k = 0; k < ENTRIES; k++)
      if (live[(pick + k) % ENTRIES]) return tid[(pick + k) % ENTRIES];
    return id_ctr;
  endfunction

  // Apply one accepted request to the mirror and queue the events it causes.
  task automatic predict_timers(tts_in_t q);
    int slot;
    int best;
    int cnt;
    bit hit;
    bit ready_now[ENTRIES];
    logic [ID_W-1:0] iv;
    slot = -1;
    cnt = 0;
    hit = 1'b0;
    case (q.opcode)
      OP_ADD: begin
        for (int i = ENTRIES - 1; i >= 0; i--) if (!live[i]) slot = i;
        if (slot < 0) begin
          queue_event(mk(RES_FULL, '0, 1'b1));
        end else begin
          id_ctr = (id_ctr == '1) ? ID_W'(1) : id_ctr + ID_W'(1);
          live[slot] = 1'b1;
          due_at[slot] = now_ticks + TIME_W'(q.delay);
          period[slot] = q.delay;
          rearm[slot] = q.repeat_req;
          tid[slot] = id_ctr;
          queue_event(mk(RES_ADDED, id_ctr, 1'b1));
        end
      end
      OP_REMOVE: begin
        for (int i = 0; i < ENTRIES; i++)
          if (live[i] && tid[i] == q.target_id) begin
            live[i] = 1'b0;
            hit = 1'b1;
          end
        if (hit) queue_event(mk(RES_REMOVED, q.target_id, 1'b1));
        else queue_event(mk(RES_NOT_FOUND, '0, 1'b1));
      end
      OP_TICK: begin
        now_ticks = now_ticks + TIME_W'(1);
        for (int i = 0; i < ENTRIES; i++) ready_now[i] = live[i] && due_at[i] <= now_ticks;
        forever begin
          best = -1;
          for (int i = 0; i < ENTRIES; i++)
            if (ready_now[i] && (best < 0 || due_at[i] < due_at[best] ||
                (due_at[i] == due_at[best] && tid[i] < tid[best])))
              best = i;
          if (best < 0) break;
          ready_now[best] = 1'b0;
          queue_event(mk(RES_EXPIRED, tid[best], 1'b0));
          cnt++;
          if (rearm[best]) begin
            iv = (period[best] == '0) ? ID_W'(1) : period[best];
            due_at[best] = now_ticks + TIME_W'(iv);
          end else begin
            live[best] = 1'b0;
          end
        end
        if (cnt > 0) pending_events[$].last = 1'b1;
        n_fired += cnt;
      end
      default: ;
    endcase
  endtask

  // Result side: random stall bursts, compare against oldest expectation.
  always @(posedge clk) begin
    tts_out_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          $error("unexpected result res=%0d id=%0d", out_data.event_res, out_data.entry_id);
          fails++;
        end else begin
          e = pending_events.pop_front();
          if (out_data.event_res !== e.event_res) begin
            $error("event_res exp %0d got %0d", e.event_res, out_data.event_res);
            fails++;
          end
          if (out_data.entry_id !== e.entry_id) begin
            $error("entry_id exp %0d got %0d", e.entry_id, out_data.entry_id);
            fails++;
          end
          if (out_data.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_data.last);
            fails++;
          end
        end
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(5) == 0) begin
        stall_cnt = $urandom_range(2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no handshake on either channel.
  int no_progress = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) no_progress <= 0;
    else no_progress <= no_progress + 1;
    if (no_progress > 5000) begin
      $display("timer_task_scheduler_tb failed");
      $finish;
    end
  end

  // Drive one request; typed expectation is checked against the predictor.
  // Valid stays high into the next request unless an idle burst drops it.
  task automatic send_req(tts_in_t q, bit has_exp, tts_out_t exp);
    while (!quiet && $urandom_range(4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= q;
    do @(posedge clk); while (!in_ready);
    predict_timers(q);
    if (has_exp && pending_events[$] != exp) begin
      $error("table row exp res=%0d id=%0d last=%0d, predicted res=%0d id=%0d",
             exp.event_res, exp.entry_id, exp.last,
             pending_events[$].event_res, pending_events[$].entry_id);
      fails++;
    end
  endtask

  dir_row_t dir_tbl[$];
  tts_in_t q;
  int op_pick;
  logic [31:0] dly;

  function automatic void add_row(dir_row_t r);
    dir_tbl = {dir_tbl, r};
  endfunction

  initial begin
    now_ticks = '0;
    id_ctr = '0;
    foreach (live[i]) live[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-table cases, delay extremes, the unused opcode, fill to full, removes of live and absent ids.
    add_row('{mk_req(OP_TICK, '0, 1'b0, '0), 1'b0, '0});
    add_row('{mk_req(OP_REMOVE, '0, 1'b0, 32'd5), 1'b1, mk(RES_NOT_FOUND, '0, 1'b1)});
    add_row('{mk_req(OP_ADD, 32'd0, 1'b0, '0), 1'b1, mk(RES_ADDED, 32'd1, 1'b1)});
    add_row('{mk_req(OP_ADD, 32'hFFFF_FFFF, 1'b1, '1), 1'b1, mk(RES_ADDED, 32'd2, 1'b1)});
    add_row('{mk_req(OP_ADD, 32'd1, 1'b1, '0), 1'b1, mk(RES_ADDED, 32'd3, 1'b1)});
    add_row('{mk_req(OP_ADD, 32'd0, 1'b1, '0), 1'b1, mk(RES_ADDED, 32'd4, 1'b1)});
    add_row('{mk_req(2'd3, '1, 1'b1, '1), 1'b0, '0});
    add_row('{mk_req(OP_TICK, '0, 1'b0, '0), 1'b0, '0});
    add_row('{mk_req(OP_TICK, '0, 1'b0, '0), 1'b0, '0});
    add_row('{mk_req(OP_REMOVE, '0, 1'b0, 32'd2), 1'b1, mk(RES_REMOVED, 32'd2, 1'b1)});
    add_row('{mk_req(OP_REMOVE, '0, 1'b0, 32'hFFFF_FFFF), 1'b1,
              mk(RES_NOT_FOUND, '0, 1'b1)});
    for (int i = 0; i < ENTRIES; i++)
      add_row('{mk_req(OP_ADD, 32'd2, i[0], '0), 1'b0, '0});
    add_row('{mk_req(OP_ADD, 32'd9, 1'b0, '0), 1'b1, mk(RES_FULL, '0, 1'b1)});
    add_row('{mk_req(OP_TICK, '0, 1'b0, '0), 1'b0, '0});
    add_row('{mk_req(OP_TICK, '0, 1'b0, '0), 1'b0, '0});
    foreach (dir_tbl[k]) send_req(dir_tbl[k].req, dir_tbl[k].has_exp, dir_tbl[k].exp);

    // Random: mostly adds/ticks with short delays; removes mostly aim at live ids.
    for (int n = 0; n < 140; n++) begin
      if (n >= 120) quiet = 1'b1;
      op_pick = $urandom_range(9);
      case ($urandom_range(7))
        0: dly = $urandom();
        1: dly = 32'hFFFF_FFFF - $urandom_range(3);
        default: dly = $urandom_range(6);
      endcase
      if (op_pick < 3 && live_count() < ENTRIES - 2)
        q = mk_req(OP_ADD, dly, 1'($urandom_range(1)), $urandom());
      else if (op_pick == 3)
        q = mk_req(OP_ADD, dly, 1'($urandom_range(1)), $urandom());
      else if (op_pick == 4)
        q = mk_req(OP_REMOVE, $urandom(), 1'($urandom_range(1)),
                   ($urandom_range(3) == 0) ? $urandom() : some_live_id());
      else if (op_pick == 5 && $urandom_range(7) == 0)
        q = mk_req(2'd3, $urandom(), 1'($urandom_range(1)), $urandom());
      else
        q = mk_req(OP_TICK, $urandom(), 1'($urandom_range(1)), $urandom());
      send_req(q, 1'b0, '0);
    end
    in_valid <= 1'b0;
    quiet = 1'b1;

    while (pending_events.size() != 0) @(posedge clk);
    repeat (4 * ENTRIES) @(posedge clk);
    if (fails == 0 && pending_events.size() == 0) begin
      $display("timer_task_scheduler_tb passed");
    end else begin
      $display("timer_task_scheduler_tb failed");
    end
    $finish;
  end
endmodule
